/* hw/rtl/dhs_pkg.sv */
// Shared types, constants and state encoding for the droplet diameter histogram block.
// Used by dhs_div and droplet_diameter_histogram_stats_top; depends on nothing else.
`default_nettype none

package dhs_pkg;

   localparam int MAX_BINS_DEF    = 32;
   localparam int VOLUME_BITS_DEF = 24;

   localparam int DIAM_W  = 26;
   localparam int VOL_W   = 24;
   localparam int BINS_W  = 6;
   localparam int IDX_W   = 6;
   localparam int COUNT_W = 16;
   localparam int SUM_W   = 40;
   localparam int SQ_W    = 64;

   // 6/pi in Q48.
   localparam logic [63:0] K_SIX_OVER_PI = 64'd537577606802124;
   localparam logic [31:0] K_LO = K_SIX_OVER_PI[31:0];
   localparam logic [31:0] K_HI = K_SIX_OVER_PI[63:32];

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int CBRT_STEPS = 26;
   localparam int SQRT_STEPS = 41;
   localparam int STEP_W     = 6;

   localparam int DIV_NW = 42;
   localparam int DIV_DW = 26;
   localparam int DIV_CW = 6;

   localparam logic [1:0] CSR_MIN_DIAMETER = 2'd0;
   localparam logic [1:0] CSR_MAX_DIAMETER = 2'd1;
   localparam logic [1:0] CSR_BINS_IN_USE  = 2'd2;

   localparam logic [DIAM_W-1:0] MAX_DIAMETER_RST = 26'd65536;
   localparam logic [BINS_W-1:0] BINS_IN_USE_RST  = 6'd16;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_MSQ, ST_MCU0, ST_MCU1, ST_MX0, ST_MX1, ST_MX2,
      ST_CBRT, ST_BIN0, ST_BIN1, ST_BINW, ST_RD, ST_WR, ST_FIN,
      ST_ERD, ST_ELD, ST_EA1, ST_EA2, ST_EA3, ST_EB1, ST_EB2, ST_EB3,
      ST_ESQ, ST_EMW, ST_EDV, ST_EDW, ST_EOUT
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum;
      logic [SQ_W-1:0]    sqsum;
   } bin_entry_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

endpackage

`default_nettype wire

/* hw/rtl/droplet_diameter_histogram_stats_top.sv */
// Top level of the droplet diameter histogram: sequencer, bin memory and arithmetic.
// Depends on dhs_pkg and instantiates dhs_div.
//
//   channel | direction | handshake            | contents
//   --------+-----------+----------------------+-------------------------------------------
//   req_    | in        | req_valid/req_stall  | mesh volume, liquid volume, patch, last flag
//   rsp_    | out       | rsp_valid/rsp_stall  | bin index, count, sum, mean, deviation, last
//   csr_    | in        | csr_write            | index, data (min, max diameter, bins in use)
//
// A region passes through the shared 32x32 multiplier, the cube root (three input
// bits per cycle), the bin division in the shared restoring divider and the memory
// read-modify-write; a region that is dropped skips all but the multiplier. The end
// pass runs, per bin in use, the square root (the mean division runs beside it) and
// the deviation division, and passes over each unused bin.
// After reset the bin memory is cleared, one entry per cycle, while req_stall stays high.
// A stalled result holds in the output register; a new request is taken while the last
// result of a frame still waits.
`default_nettype none

module droplet_diameter_histogram_stats_top #(
   parameter int MAX_BINS    = dhs_pkg::MAX_BINS_DEF,
   parameter int VOLUME_BITS = dhs_pkg::VOLUME_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dhs_pkg::VOL_W-1:0]     req_region_mesh_volume,
   input  wire logic [dhs_pkg::VOL_W-1:0]     req_region_liquid_volume,
   input  wire logic                          req_touches_patch,
   input  wire logic                          req_last_region,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [dhs_pkg::IDX_W-1:0]          rsp_bin_index,
   output logic [dhs_pkg::COUNT_W-1:0]        rsp_region_count,
   output logic [dhs_pkg::SUM_W-1:0]          rsp_volume_sum,
   output logic [dhs_pkg::VOL_W-1:0]          rsp_volume_mean,
   output logic [dhs_pkg::VOL_W-1:0]          rsp_volume_deviation,
   output logic                               rsp_last_bin,

   input  wire logic                          csr_write,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [dhs_pkg::DIAM_W-1:0]    csr_wdata
);

   localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NBW = $clog2(MAX_BINS + 1);
   localparam logic [dhs_pkg::VOL_W-1:0] VMASK =
      dhs_pkg::VOL_W'((64'd1 << VOLUME_BITS) - 64'd1);

   // Configuration registers.
   logic [dhs_pkg::DIAM_W-1:0] min_ff, max_ff;
   logic [dhs_pkg::BINS_W-1:0] bins_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         max_ff  <= dhs_pkg::MAX_DIAMETER_RST;
         bins_ff <= dhs_pkg::BINS_IN_USE_RST;
      end else if (csr_write) begin
         case (csr_index)
            dhs_pkg::CSR_MIN_DIAMETER: min_ff  <= csr_wdata;
            dhs_pkg::CSR_MAX_DIAMETER: max_ff  <= csr_wdata;
            dhs_pkg::CSR_BINS_IN_USE:  bins_ff <= csr_wdata[dhs_pkg::BINS_W-1:0];
            default: ;
         endcase
      end
   end

   // Number of bins in effect: zero acts as one, large values clamp to the memory depth.
   logic [NBW-1:0] nb, nb_last;
   always_comb begin
      if (bins_ff == '0) begin
         nb = NBW'(1);
      end else if (int'(bins_ff) > MAX_BINS) begin
         nb = NBW'(MAX_BINS);
      end else begin
         nb = NBW'(bins_ff);
      end
      nb_last = nb - 1'b1;
   end

   dhs_pkg::state_type state_ff, state_in;

   // Request fields.
   logic [dhs_pkg::VOL_W-1:0] mesh_ff, liq_ff;
   logic                      patch_ff, last_ff;

   // Arithmetic registers.
   logic [63:0]  prod_ff;
   logic [19:0]  m2hi_ff;
   logic [63:0]  acc_ff;
   logic         drop_ff;
   logic [81:0]  sh_ff;
   logic [59:0]  rem_ff;
   logic [40:0]  root_ff;
   logic [51:0]  rsq_ff;
   logic [dhs_pkg::STEP_W-1:0] step_ff;
   logic [47:0]  liqsq_ff;
   logic [AW-1:0] bin_ff, k_ff;
   logic [81:0]  a_ff, b_ff;
   logic [dhs_pkg::VOL_W-1:0] mean_ff;
   dhs_pkg::bin_entry_type ent_ff;

   // Bin memory, one entry per bin: count, volume sum and square sum.
   dhs_pkg::bin_entry_type bin_mem_ff [MAX_BINS];
   dhs_pkg::bin_entry_type mem_rdata_ff, mem_wdata;
   logic                   mem_re, mem_we;
   logic [AW-1:0]          mem_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= bin_mem_ff[mem_addr];
      end
   end

   // Shared multiplier, one product per cycle, registered.
   logic        mul_en;
   logic [31:0] mul_a, mul_b;
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Shared divider.
   dhs_pkg::div_req_type          div_req;
   logic                          div_busy;
   logic [dhs_pkg::DIV_NW-1:0]    div_quot;

   dhs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_busy (div_busy),
      .div_quot (div_quot)
   );

   // Result register.
   logic                       rsp_valid_ff;
   logic [dhs_pkg::IDX_W-1:0]  rsp_bin_index_ff;
   logic [dhs_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [dhs_pkg::SUM_W-1:0]  rsp_sum_ff;
   logic [dhs_pkg::VOL_W-1:0]  rsp_mean_ff, rsp_dev_ff;
   logic                       rsp_last_ff;
   logic                       out_free, rsp_load;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Derived conditions.
   logic [dhs_pkg::DIAM_W-1:0] diam;
   logic                       k_in_use, k_at_end, diam_low, range_empty;
   logic                       cbrt_done, sqrt_done;

   assign diam        = root_ff[dhs_pkg::DIAM_W-1:0];
   assign k_in_use    = int'(k_ff) < int'(nb);
   assign k_at_end    = int'(k_ff) == MAX_BINS - 1;
   assign diam_low    = diam < min_ff;
   assign range_empty = max_ff <= min_ff;
   assign cbrt_done   = step_ff == dhs_pkg::STEP_W'(dhs_pkg::CBRT_STEPS - 1);
   assign sqrt_done   = step_ff == dhs_pkg::STEP_W'(dhs_pkg::SQRT_STEPS - 1);

   // Volume limit: drop when max_diameter cubed is not above 6 * mesh volume in Q48.
   logic [77:0] max_cube, vol_limit;
   logic [26:0] six_mesh;
   assign max_cube  = 78'(acc_ff) + (78'(prod_ff) << 32);
   assign six_mesh  = (27'(mesh_ff) << 2) + (27'(mesh_ff) << 1);
   assign vol_limit = 78'(six_mesh) << 48;

   // Cube root step: three radicand bits enter the remainder each cycle.
   // The square of the partial root is tracked so the trial needs only adds.
   logic [59:0] c_rem3, c_trial;
   logic [25:0] c_y2;
   logic [51:0] c_ysq4;
   logic [53:0] c_t;
   logic        c_take;
   always_comb begin
      c_rem3  = {rem_ff[56:0], sh_ff[81:79]};
      c_y2    = {root_ff[24:0], 1'b0};
      c_ysq4  = {rsq_ff[49:0], 2'b00};
      c_t     = 54'(c_ysq4) + 54'(c_y2);
      c_trial = (60'(c_t) << 1) + 60'(c_t) + 60'd1;
      c_take  = c_rem3 >= c_trial;
   end

   // Square root step: two radicand bits a cycle.
   logic [59:0] s_rem2, s_trial;
   logic        s_take;
   always_comb begin
      s_rem2  = {rem_ff[57:0], sh_ff[81:80]};
      s_trial = 60'({root_ff, 2'b01});
      s_take  = s_rem2 >= s_trial;
   end

   // Variance numerator n*q - s*s, clamped at zero.
   logic [81:0] b_total, var_num;
   assign b_total = b_ff + (82'(prod_ff) << 64);
   assign var_num = (b_total <= a_ff) ? (a_ff - b_total) : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dhs_pkg::ST_CLEAR: if (k_at_end) state_in = dhs_pkg::ST_IDLE;
         dhs_pkg::ST_IDLE:  if (req_valid) state_in = dhs_pkg::ST_MSQ;
         dhs_pkg::ST_MSQ:   state_in = dhs_pkg::ST_MCU0;
         dhs_pkg::ST_MCU0:  state_in = dhs_pkg::ST_MCU1;
         dhs_pkg::ST_MCU1:  state_in = dhs_pkg::ST_MX0;
         dhs_pkg::ST_MX0:   state_in = dhs_pkg::ST_MX1;
         dhs_pkg::ST_MX1:   state_in = dhs_pkg::ST_MX2;
         dhs_pkg::ST_MX2:   state_in = drop_ff ? dhs_pkg::ST_FIN : dhs_pkg::ST_CBRT;
         dhs_pkg::ST_CBRT:  if (cbrt_done) state_in = dhs_pkg::ST_BIN0;
         dhs_pkg::ST_BIN0: begin
            if (diam_low) begin
               state_in = dhs_pkg::ST_FIN;
            end else if (range_empty) begin
               state_in = dhs_pkg::ST_RD;
            end else begin
               state_in = dhs_pkg::ST_BIN1;
            end
         end
         dhs_pkg::ST_BIN1:  state_in = dhs_pkg::ST_BINW;
         dhs_pkg::ST_BINW:  if (!div_busy) state_in = dhs_pkg::ST_RD;
         dhs_pkg::ST_RD:    state_in = dhs_pkg::ST_WR;
         dhs_pkg::ST_WR:    state_in = dhs_pkg::ST_FIN;
         dhs_pkg::ST_FIN:   state_in = last_ff ? dhs_pkg::ST_ERD : dhs_pkg::ST_IDLE;
         dhs_pkg::ST_ERD: begin
            if (k_in_use) begin
               state_in = dhs_pkg::ST_ELD;
            end else if (k_at_end) begin
               state_in = dhs_pkg::ST_IDLE;
            end
         end
         dhs_pkg::ST_ELD:   state_in = dhs_pkg::ST_EA1;
         dhs_pkg::ST_EA1:   state_in = dhs_pkg::ST_EA2;
         dhs_pkg::ST_EA2:   state_in = dhs_pkg::ST_EA3;
         dhs_pkg::ST_EA3:   state_in = dhs_pkg::ST_EB1;
         dhs_pkg::ST_EB1:   state_in = dhs_pkg::ST_EB2;
         dhs_pkg::ST_EB2:   state_in = dhs_pkg::ST_EB3;
         dhs_pkg::ST_EB3:   state_in = dhs_pkg::ST_ESQ;
         dhs_pkg::ST_ESQ:   if (sqrt_done) state_in = dhs_pkg::ST_EMW;
         dhs_pkg::ST_EMW:   if (!div_busy) state_in = dhs_pkg::ST_EDV;
         dhs_pkg::ST_EDV:   state_in = dhs_pkg::ST_EDW;
         dhs_pkg::ST_EDW:   if (!div_busy) state_in = dhs_pkg::ST_EOUT;
         dhs_pkg::ST_EOUT: begin
            if (out_free) begin
               state_in = k_at_end ? dhs_pkg::ST_IDLE : dhs_pkg::ST_ERD;
            end
         end
         default: state_in = dhs_pkg::ST_IDLE;
      endcase
   end

   // Control outputs per state.
   always_comb begin
      req_stall = (state_ff != dhs_pkg::ST_IDLE);
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = k_ff;
      mem_wdata = '0;
      div_req   = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         dhs_pkg::ST_CLEAR: mem_we = 1'b1;
         dhs_pkg::ST_MSQ: begin
            mul_en = 1'b1;
            mul_a  = 32'(max_ff);
            mul_b  = 32'(max_ff);
         end
         dhs_pkg::ST_MCU0: begin
            mul_en = 1'b1;
            mul_a  = prod_ff[31:0];
            mul_b  = 32'(max_ff);
         end
         dhs_pkg::ST_MCU1: begin
            mul_en = 1'b1;
            mul_a  = 32'(m2hi_ff);
            mul_b  = 32'(max_ff);
         end
         dhs_pkg::ST_MX0: begin
            mul_en = 1'b1;
            mul_a  = 32'(liq_ff);
            mul_b  = dhs_pkg::K_LO;
         end
         dhs_pkg::ST_MX1: begin
            mul_en = 1'b1;
            mul_a  = 32'(liq_ff);
            mul_b  = dhs_pkg::K_HI;
         end
         dhs_pkg::ST_MX2: begin
            mul_en = 1'b1;
            mul_a  = 32'(liq_ff);
            mul_b  = 32'(liq_ff);
         end
         dhs_pkg::ST_BIN0: begin
            mul_en = 1'b1;
            mul_a  = 32'(diam - min_ff);
            mul_b  = 32'(nb);
         end
         dhs_pkg::ST_BIN1: begin
            div_req.start = 1'b1;
            div_req.num   = dhs_pkg::DIV_NW'(prod_ff[32:0]);
            div_req.den   = max_ff - min_ff;
         end
         dhs_pkg::ST_RD: begin
            mem_re   = 1'b1;
            mem_addr = bin_ff;
         end
         dhs_pkg::ST_WR: begin
            mem_addr        = bin_ff;
            mem_we          = (mem_rdata_ff.count != dhs_pkg::COUNT_MAX);
            mem_wdata.count = mem_rdata_ff.count + 1'b1;
            mem_wdata.sum   = mem_rdata_ff.sum + dhs_pkg::SUM_W'(liq_ff);
            mem_wdata.sqsum = mem_rdata_ff.sqsum + dhs_pkg::SQ_W'(liqsq_ff);
         end
         dhs_pkg::ST_ERD: begin
            mem_re = k_in_use;
            mem_we = !k_in_use;
         end
         dhs_pkg::ST_EA1: begin
            mul_en = 1'b1;
            mul_a  = 32'(ent_ff.count);
            mul_b  = ent_ff.sqsum[31:0];
         end
         dhs_pkg::ST_EA2: begin
            mul_en = 1'b1;
            mul_a  = 32'(ent_ff.count);
            mul_b  = ent_ff.sqsum[63:32];
         end
         dhs_pkg::ST_EA3: begin
            mul_en = 1'b1;
            mul_a  = ent_ff.sum[31:0];
            mul_b  = ent_ff.sum[31:0];
         end
         dhs_pkg::ST_EB1: begin
            mul_en = 1'b1;
            mul_a  = ent_ff.sum[31:0];
            mul_b  = 32'(ent_ff.sum[39:32]);
         end
         dhs_pkg::ST_EB2: begin
            mul_en = 1'b1;
            mul_a  = 32'(ent_ff.sum[39:32]);
            mul_b  = 32'(ent_ff.sum[39:32]);
         end
         dhs_pkg::ST_EB3: begin
            div_req.start = 1'b1;
            div_req.num   = dhs_pkg::DIV_NW'(ent_ff.sum);
            div_req.den   = dhs_pkg::DIV_DW'(ent_ff.count);
         end
         dhs_pkg::ST_EDV: begin
            div_req.start = 1'b1;
            div_req.num   = dhs_pkg::DIV_NW'(root_ff);
            div_req.den   = dhs_pkg::DIV_DW'(ent_ff.count);
         end
         dhs_pkg::ST_EOUT: begin
            rsp_load = out_free;
            mem_we   = out_free;
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dhs_pkg::ST_CLEAR;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            dhs_pkg::ST_CLEAR: k_ff <= k_at_end ? '0 : k_ff + 1'b1;
            dhs_pkg::ST_FIN:   k_ff <= '0;
            dhs_pkg::ST_ERD: begin
               if (!k_in_use) begin
                  k_ff <= k_at_end ? '0 : k_ff + 1'b1;
               end
            end
            dhs_pkg::ST_EOUT: begin
               if (out_free) begin
                  k_ff <= k_at_end ? '0 : k_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         dhs_pkg::ST_IDLE: begin
            mesh_ff  <= req_region_mesh_volume & VMASK;
            liq_ff   <= req_region_liquid_volume & VMASK;
            patch_ff <= req_touches_patch;
            last_ff  <= req_last_region;
         end
         dhs_pkg::ST_MCU0: m2hi_ff <= prod_ff[51:32];
         dhs_pkg::ST_MCU1: acc_ff  <= prod_ff;
         dhs_pkg::ST_MX0:  drop_ff <= patch_ff || (max_cube <= vol_limit);
         dhs_pkg::ST_MX1:  acc_ff  <= prod_ff;
         dhs_pkg::ST_MX2: begin
            // Radicand is liquid volume times 6/pi in Q48, aligned to the top.
            sh_ff   <= (82'(acc_ff) + (82'(prod_ff) << 32)) << 4;
            rem_ff  <= '0;
            root_ff <= '0;
            rsq_ff  <= '0;
            step_ff <= '0;
         end
         dhs_pkg::ST_CBRT: begin
            sh_ff   <= sh_ff << 3;
            step_ff <= step_ff + 1'b1;
            if (c_take) begin
               rem_ff  <= c_rem3 - c_trial;
               rsq_ff  <= c_ysq4 + (52'(c_y2) << 1) + 52'd1;
               root_ff <= 41'(c_y2) + 41'd1;
            end else begin
               rem_ff  <= c_rem3;
               rsq_ff  <= c_ysq4;
               root_ff <= 41'(c_y2);
            end
         end
         dhs_pkg::ST_BIN0: begin
            liqsq_ff <= prod_ff[47:0];
            bin_ff   <= AW'(nb_last);
         end
         dhs_pkg::ST_BINW: begin
            if (!div_busy) begin
               // Diameters at or past the top land in the last bin.
               bin_ff <= (div_quot >= dhs_pkg::DIV_NW'(nb)) ? AW'(nb_last) : AW'(div_quot);
            end
         end
         dhs_pkg::ST_ELD: ent_ff <= mem_rdata_ff;
         dhs_pkg::ST_EA2: acc_ff <= prod_ff;
         dhs_pkg::ST_EA3: a_ff   <= 82'(acc_ff) + (82'(prod_ff) << 32);
         dhs_pkg::ST_EB1: acc_ff <= prod_ff;
         dhs_pkg::ST_EB2: b_ff   <= 82'(acc_ff) + (82'(prod_ff) << 33);
         dhs_pkg::ST_EB3: begin
            sh_ff   <= var_num;
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= '0;
         end
         dhs_pkg::ST_ESQ: begin
            sh_ff   <= sh_ff << 2;
            step_ff <= step_ff + 1'b1;
            if (s_take) begin
               rem_ff  <= s_rem2 - s_trial;
               root_ff <= {root_ff[39:0], 1'b1};
            end else begin
               rem_ff  <= s_rem2;
               root_ff <= {root_ff[39:0], 1'b0};
            end
         end
         dhs_pkg::ST_EMW: begin
            if (!div_busy) begin
               mean_ff <= div_quot[dhs_pkg::VOL_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // Result payload; an empty bin reports zero mean and deviation.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bin_index_ff <= dhs_pkg::IDX_W'(k_ff);
         rsp_count_ff     <= ent_ff.count;
         rsp_sum_ff       <= ent_ff.sum;
         rsp_mean_ff      <= (ent_ff.count == '0) ? '0 : mean_ff;
         rsp_dev_ff       <= (ent_ff.count == '0) ? '0 : div_quot[dhs_pkg::VOL_W-1:0];
         rsp_last_ff      <= (int'(k_ff) == int'(nb_last));
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bin_index        = rsp_bin_index_ff;
   assign rsp_region_count     = rsp_count_ff;
   assign rsp_volume_sum       = rsp_sum_ff;
   assign rsp_volume_mean      = rsp_mean_ff;
   assign rsp_volume_deviation = rsp_dev_ff;
   assign rsp_last_bin         = rsp_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/dhs_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the bin and statistics paths.
// Depends on dhs_pkg for widths and the request struct.
`default_nettype none

module dhs_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dhs_pkg::div_req_type        div_req,
   output logic                             div_busy,
   output logic [dhs_pkg::DIV_NW-1:0]       div_quot
);

   logic                        busy_ff, busy_in;
   logic [dhs_pkg::DIV_CW-1:0]  cnt_ff, cnt_in;
   logic [dhs_pkg::DIV_NW-1:0]  num_ff, num_in;
   logic [dhs_pkg::DIV_DW-1:0]  rem_ff, rem_in;
   logic [dhs_pkg::DIV_DW-1:0]  den_ff, den_in;
   logic [dhs_pkg::DIV_DW:0]    trial;
   logic [dhs_pkg::DIV_DW:0]    diff;
   logic                        ge;

   assign trial = {rem_ff, num_ff[dhs_pkg::DIV_NW-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == dhs_pkg::DIV_CW'(dhs_pkg::DIV_NW - 1)) begin
            busy_in = 1'b0;
         end
         num_in = {num_ff[dhs_pkg::DIV_NW-2:0], ge};
         rem_in = ge ? diff[dhs_pkg::DIV_DW-1:0] : trial[dhs_pkg::DIV_DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_busy = busy_ff;
   assign div_quot = num_ff;

endmodule

`default_nettype wire

/* hw/rtl/dhs_checker.sv */
// Port-level checks for droplet_diameter_histogram_stats_top, attached by bind.
// Depends on the top level's port names only.
`default_nettype none

module dhs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [5:0]  rsp_bin_index,
   input wire logic        rsp_last_bin
);

   // The bin memory is swept clear right after reset, so no request is taken then.
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during clearing sweep");

   // One request at a time: the sequencer is busy in the cycle after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_bin_index) && $stable(rsp_last_bin))
      else $error("stalled result changed");

endmodule

bind droplet_diameter_histogram_stats_top dhs_checker u_dhs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_bin_index (rsp_bin_index),
   .rsp_last_bin  (rsp_last_bin)
);

`default_nettype wire
